@@ rtl/core/wsu_pkg.sv @@
// shared types, constants and the character classifier for the string-to-unsigned converter
package wsu_pkg;

    localparam int CHAR_W  = 21;
    localparam int RADIX_W = 6;
    localparam int DIG_W   = 6;
    localparam int END_W   = 12;

    localparam logic [END_W-1:0]   END_MAX     = 12'd4095;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] BASE_AUTO   = 6'd0;
    localparam logic [RADIX_W-1:0] BASE_OCT    = 6'd8;
    localparam logic [RADIX_W-1:0] BASE_DEC    = 6'd10;
    localparam logic [RADIX_W-1:0] BASE_HEX    = 6'd16;

    // digit codes
    localparam logic [DIG_W-1:0] DIG_NONE  = 6'd63;
    localparam logic [DIG_W-1:0] DIG_ZERO  = 6'd0;
    localparam logic [DIG_W-1:0] DIG_X     = 6'd33;
    localparam logic [DIG_W-1:0] DIG_ALPHA = 6'd10;

    // character codes
    localparam logic [CHAR_W-1:0] CH_SPACE = 21'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 21'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 21'h0D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 21'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 21'h2D;
    localparam logic [CHAR_W-1:0] CH_0     = 21'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 21'h39;
    localparam logic [CHAR_W-1:0] CH_UA    = 21'h41;
    localparam logic [CHAR_W-1:0] CH_UZ    = 21'h5A;
    localparam logic [CHAR_W-1:0] CH_LA    = 21'h61;
    localparam logic [CHAR_W-1:0] CH_LZ    = 21'h7A;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // one classified character item
    typedef struct packed {
        logic             start;
        logic [DIG_W-1:0] dig;
        logic             space;
        logic             minus;
        logic             plus;
    } char_class_t;

    // digit value of a character, DIG_NONE when it is no digit in any base
    function automatic logic [DIG_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
        logic [DIG_W-1:0] d;
        d = DIG_NONE;
        if (c >= CH_0 && c <= CH_9)
        begin
            d = DIG_W'(c - CH_0);
        end
        else if (c >= CH_LA && c <= CH_LZ)
        begin
            d = DIG_W'(c - CH_LA) + DIG_ALPHA;
        end
        else if (c >= CH_UA && c <= CH_UZ)
        begin
            d = DIG_W'(c - CH_UA) + DIG_ALPHA;
        end
        return d;
    endfunction

endpackage

@@ rtl/core/wsu_front.sv @@
// front stage: accepts characters, classifies them and registers the class item
module wsu_front
    import wsu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CHAR_W-1:0] char_code,
    input  logic              start_of_string,
    output logic              cls_valid,
    input  logic              cls_ready,
    output char_class_t       cls_item
);

    logic        valid_reg;
    logic        valid_next;
    char_class_t item_reg;
    char_class_t item_next;
    logic        accept;

    // stage is free when empty or when its item moves on
    assign in_ready = !valid_reg || cls_ready;
    assign accept   = in_valid && in_ready;

    // classification of the incoming character
    always_comb
    begin
        item_next.start = start_of_string;
        item_next.dig   = digit_of(char_code);
        item_next.space = (char_code == CH_SPACE) || (char_code >= CH_TAB && char_code <= CH_CR);
        item_next.minus = (char_code == CH_MINUS);
        item_next.plus  = (char_code == CH_PLUS);
    end

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (cls_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    // valid flag under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

    assign cls_valid = valid_reg;
    assign cls_item  = item_reg;

endmodule

@@ rtl/core/wsu_queue.sv @@
// short queue of classified items between front and back
module wsu_queue
    import wsu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push_valid,
    output logic        push_ready,
    input  char_class_t push_item,
    output logic        pop_valid,
    input  logic        pop_ready,
    output char_class_t pop_item
);

    char_class_t       slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;
    logic              pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slots[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage slots
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ rtl/core/wsu_back.sv @@
// back stage: parse state machine, digit accumulator and result register
module wsu_back
    import wsu_pkg::*;
#(
    parameter int VALUE_BITS = 64,
    parameter int MAX_LEN    = 4095
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [RADIX_W-1:0]    radix,
    input  logic                  cls_valid,
    output logic                  cls_ready,
    input  char_class_t           cls_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [VALUE_BITS-1:0] value,
    output logic                  overflow,
    output logic                  bad_radix,
    output logic                  digits_found,
    output logic [END_W-1:0]      end_offset
);

    localparam int POS_W = $clog2(MAX_LEN + 1);
    localparam int MAC_W = VALUE_BITS + RADIX_W + 1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SPACE,
        PH_SIGNED,
        PH_ZERO,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    phase_t                phase_reg;
    phase_t                phase_next;
    phase_t                phase_cur;
    logic [VALUE_BITS-1:0] acc_reg;
    logic [VALUE_BITS-1:0] acc_next;
    logic [RADIX_W-1:0]    base_reg;
    logic [RADIX_W-1:0]    base_next;
    logic                  minus_reg;
    logic                  minus_next;
    logic                  dseen_reg;
    logic                  dseen_next;
    logic                  ovf_reg;
    logic                  ovf_next;
    logic [POS_W-1:0]      pos_reg;
    logic [POS_W-1:0]      pos_next;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [VALUE_BITS-1:0] value_reg;
    logic                  overflow_reg;
    logic                  bad_radix_reg;
    logic                  digits_found_reg;
    logic [END_W-1:0]      end_offset_reg;

    logic                  pop;
    logic                  radix_bad;
    logic                  active;
    logic                  first;
    logic                  take;
    logic                  emit;
    logic                  emit_bad;
    logic [MAC_W-1:0]      mac;
    logic [VALUE_BITS-1:0] res_value;
    logic [END_W-1:0]      res_end;

    // an item is taken whenever the result register can take a result
    assign pop       = cls_valid && (!out_valid_reg || out_ready);
    assign cls_ready = !out_valid_reg || out_ready;
    assign radix_bad = (radix != BASE_AUTO) && (radix < RADIX_MIN || radix > RADIX_MAX);

    // parse step for one character
    always_comb
    begin
        active     = 1'b0;
        first      = 1'b0;
        take       = 1'b0;
        emit       = 1'b0;
        emit_bad   = 1'b0;
        mac        = '0;
        phase_cur  = phase_reg;
        phase_next = phase_reg;
        acc_next   = acc_reg;
        base_next  = base_reg;
        minus_next = minus_reg;
        dseen_next = dseen_reg;
        ovf_next   = ovf_reg;
        pos_next   = pos_reg;

        // start of a conversion or position advance
        if (pop)
        begin
            if (cls_item.start)
            begin
                acc_next   = '0;
                base_next  = radix;
                minus_next = 1'b0;
                dseen_next = 1'b0;
                ovf_next   = 1'b0;
                pos_next   = '0;
                if (radix_bad)
                begin
                    emit_bad   = 1'b1;
                    phase_next = PH_DONE;
                end
                else
                begin
                    active     = 1'b1;
                    phase_cur  = PH_SPACE;
                    phase_next = PH_SPACE;
                end
            end
            else if (phase_reg != PH_IDLE && phase_reg != PH_DONE)
            begin
                active = 1'b1;
                if (pos_reg < POS_W'(MAX_LEN))
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end
        end

        // phase dispatch
        if (active)
        begin
            case (phase_cur)
                PH_SPACE:
                begin
                    if (cls_item.space)
                    begin
                        phase_next = PH_SPACE;
                    end
                    else if (cls_item.minus)
                    begin
                        minus_next = 1'b1;
                        phase_next = PH_SIGNED;
                    end
                    else if (cls_item.plus)
                    begin
                        phase_next = PH_SIGNED;
                    end
                    else
                    begin
                        first = 1'b1;
                    end
                end
                PH_SIGNED:
                begin
                    first = 1'b1;
                end
                PH_ZERO:
                begin
                    if (cls_item.dig == DIG_X)
                    begin
                        base_next  = BASE_HEX;
                        phase_next = PH_DIGITS;
                    end
                    else
                    begin
                        if (base_next == BASE_AUTO)
                        begin
                            base_next = BASE_OCT;
                        end
                        acc_next   = '0;
                        dseen_next = 1'b1;
                        phase_next = PH_DIGITS;
                        take       = 1'b1;
                    end
                end
                PH_DIGITS:
                begin
                    take = 1'b1;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        // first character after whitespace and sign
        if (first)
        begin
            if ((base_next == BASE_AUTO || base_next == BASE_HEX) && cls_item.dig == DIG_ZERO)
            begin
                phase_next = PH_ZERO;
            end
            else
            begin
                if (base_next == BASE_AUTO)
                begin
                    base_next = BASE_DEC;
                end
                phase_next = PH_DIGITS;
                take       = 1'b1;
            end
        end

        // digit accumulate with saturation, or end of number
        if (take)
        begin
            mac = MAC_W'(acc_next) * MAC_W'(base_next) + MAC_W'(cls_item.dig);
            if (cls_item.dig >= base_next)
            begin
                emit       = 1'b1;
                phase_next = PH_DONE;
            end
            else if (!ovf_next)
            begin
                if (mac[MAC_W-1:VALUE_BITS] != '0)
                begin
                    ovf_next = 1'b1;
                    acc_next = '1;
                end
                else
                begin
                    acc_next = mac[VALUE_BITS-1:0];
                end
                dseen_next = 1'b1;
            end
        end
    end

    // result fields
    always_comb
    begin
        if (ovf_next)
        begin
            res_value = '1;
        end
        else if (minus_next && dseen_next)
        begin
            res_value = -acc_next;
        end
        else
        begin
            res_value = acc_next;
        end
        if (!dseen_next)
        begin
            res_end = '0;
        end
        else if (32'(pos_next) > 32'(END_MAX))
        begin
            res_end = END_MAX;
        end
        else
        begin
            res_end = END_W'(pos_next);
        end
    end

    always_comb
    begin
        if (emit || emit_bad)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // parse state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            acc_reg          <= '0;
            base_reg         <= '0;
            minus_reg        <= 1'b0;
            dseen_reg        <= 1'b0;
            ovf_reg          <= 1'b0;
            pos_reg          <= '0;
            out_valid_reg    <= 1'b0;
            value_reg        <= '0;
            overflow_reg     <= 1'b0;
            bad_radix_reg    <= 1'b0;
            digits_found_reg <= 1'b0;
            end_offset_reg   <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            base_reg      <= base_next;
            minus_reg     <= minus_next;
            dseen_reg     <= dseen_next;
            ovf_reg       <= ovf_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            if (emit_bad)
            begin
                value_reg        <= '0;
                overflow_reg     <= 1'b0;
                bad_radix_reg    <= 1'b1;
                digits_found_reg <= 1'b0;
                end_offset_reg   <= '0;
            end
            else if (emit)
            begin
                value_reg        <= res_value;
                overflow_reg     <= ovf_next;
                bad_radix_reg    <= 1'b0;
                digits_found_reg <= dseen_next;
                end_offset_reg   <= res_end;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign value        = value_reg;
    assign overflow     = overflow_reg;
    assign bad_radix    = bad_radix_reg;
    assign digits_found = digits_found_reg;
    assign end_offset   = end_offset_reg;

endmodule

@@ rtl/core/wide_string_to_unsigned.sv @@
// top level of the wide-character string to unsigned integer converter
//
// Input channel (in_valid/in_ready) takes one character per item: char_code
// and start_of_string, which opens a new conversion. Each conversion gives one
// item on the output channel (out_valid/out_ready) when the first character
// that ends the number arrives; characters after that are dropped until the
// next start. The config channel (cfg_valid/cfg_ready) writes the radix
// register (2..36, or 0 for automatic base); it is always ready and is sampled
// when a conversion starts. The user must write it only while the converter is
// idle; the block does not enforce this. Throughput is one character per cycle
// while the receiver does not stall: the digit step is one multiply by the
// base and one add per cycle in the back stage. The result item passes through
// the front register, the queue and the result register. When the receiver
// stalls, the result register holds and the four-entry queue keeps taking
// characters until it fills; then in_ready drops. Reset empties both stages
// and the queue, returns the parser to idle and sets the radix to 10.
module wide_string_to_unsigned
    import wsu_pkg::*;
#(
    parameter int VALUE_BITS = 64,
    parameter int MAX_LEN    = 4095
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [RADIX_W-1:0]    radix,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [CHAR_W-1:0]     char_code,
    input  logic                  start_of_string,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [VALUE_BITS-1:0] value,
    output logic                  overflow,
    output logic                  bad_radix,
    output logic                  digits_found,
    output logic [END_W-1:0]      end_offset
);

    logic [RADIX_W-1:0] radix_reg;
    logic               f_valid;
    logic               f_ready;
    char_class_t        f_item;
    logic               q_valid;
    logic               q_ready;
    char_class_t        q_item;

    // radix register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            radix_reg <= radix;
        end
    end

    wsu_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .char_code       (char_code),
        .start_of_string (start_of_string),
        .cls_valid       (f_valid),
        .cls_ready       (f_ready),
        .cls_item        (f_item)
    );

    wsu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    wsu_back #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_LEN    (MAX_LEN)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .radix        (radix_reg),
        .cls_valid    (q_valid),
        .cls_ready    (q_ready),
        .cls_item     (q_item),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .value        (value),
        .overflow     (overflow),
        .bad_radix    (bad_radix),
        .digits_found (digits_found),
        .end_offset   (end_offset)
    );

endmodule

@@ rtl/core/wsu_checker.sv @@
// port-level checks on the converter's result channel, bound to the top level
module wsu_checker
    import wsu_pkg::*;
#(
    parameter int VALUE_BITS = 64
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [VALUE_BITS-1:0] value,
    input logic                  overflow,
    input logic                  bad_radix,
    input logic                  digits_found,
    input logic [END_W-1:0]      end_offset
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // a bad radix result carries nothing else
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_radix |-> value == '0 && !overflow && !digits_found && end_offset == '0)
        else $error("bad radix result has extra content");

    // no digits means zero value and zero end offset
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !digits_found |-> value == '0 && end_offset == '0 && !overflow)
        else $error("digitless result not zero");

    // overflow implies digits and saturated value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> digits_found && !bad_radix && (&value))
        else $error("overflow result not saturated");

endmodule

bind wide_string_to_unsigned wsu_checker #(.VALUE_BITS(VALUE_BITS)) u_wsu_checker (.*);

@@ tb/testbench.sv @@
// self-checking testbench for the wide string to unsigned converter
module testbench;
    import wsu_pkg::*;

    localparam int VALUE_W        = 64;
    localparam int POS_LIMIT      = 4095;
    localparam int RANDOM_ITEMS   = 1500;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int CODE_MAX       = 1114111;

    localparam logic [VALUE_W-1:0] ALL_ONES = '1;
    localparam logic [CHAR_W-1:0]  CH_NUL   = 21'h00;
    localparam logic [CHAR_W-1:0]  CH_LX    = 21'h78;
    localparam logic [CHAR_W-1:0]  CH_UX    = 21'h58;
    localparam logic [CHAR_W-1:0]  CH_DOT   = 21'h2E;
    localparam logic [CHAR_W-1:0]  CH_TOP   = 21'h10FFFF;

    typedef logic [CHAR_W-1:0] char_t;

    typedef enum logic [2:0] {
        P_IDLE,
        P_SPACE,
        P_SIGNED,
        P_ZERO,
        P_DIGITS,
        P_DONE
    } parse_phase_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               overflow;
        logic               bad_radix;
        logic               digits_found;
        logic [END_W-1:0]   end_offset;
    } conversion_t;

    // parses the character stream alongside the block and holds the pending conversions
    class conversion_tracker;
        conversion_t        expected_conversions[$];
        int                 errors;
        logic [RADIX_W-1:0] radix_reg;
        parse_phase_t       phase;
        logic [VALUE_W-1:0] acc;
        logic [RADIX_W-1:0] base;
        bit                 minus_seen;
        bit                 digit_seen;
        bit                 ovf;
        logic [END_W-1:0]   pos;

        function new();
            errors     = 0;
            radix_reg  = RADIX_RESET;
            phase      = P_IDLE;
            acc        = '0;
            base       = '0;
            minus_seen = 0;
            digit_seen = 0;
            ovf        = 0;
            pos        = '0;
        endfunction

        function int pending();
            return expected_conversions.size();
        endfunction

        // value of a character as a digit, 99 when it is none
        function int unsigned char_digit(char_t c);
            if (c >= CH_0 && c <= CH_9)
                return c - CH_0;
            if (c >= CH_LA && c <= CH_LZ)
                return c - CH_LA + 10;
            if (c >= CH_UA && c <= CH_UZ)
                return c - CH_UA + 10;
            return 99;
        endfunction

        function bit is_blank(char_t c);
            return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
        endfunction

        // number ends here
        function void finish_number();
            conversion_t e;
            if (ovf)
                e.value = ALL_ONES;
            else if (minus_seen && digit_seen)
                e.value = '0 - acc;
            else
                e.value = acc;
            e.overflow     = ovf;
            e.bad_radix    = 1'b0;
            e.digits_found = digit_seen;
            e.end_offset   = digit_seen ? pos : '0;
            expected_conversions.push_back(e);
            phase = P_DONE;
        endfunction

        // one digit step with saturation on overflow
        function void accumulate(char_t c);
            int unsigned        d;
            logic [VALUE_W-1:0] b;
            logic [VALUE_W-1:0] cutoff;
            logic [VALUE_W-1:0] cutlim;
            if (base < RADIX_MIN || base > RADIX_MAX)
                base = BASE_DEC;
            b = VALUE_W'(base);
            d = char_digit(c);
            if (d >= b)
            begin
                finish_number();
                return;
            end
            if (ovf)
                return;
            cutoff = ALL_ONES / b;
            cutlim = ALL_ONES % b;
            if (acc > cutoff || (acc == cutoff && d > cutlim))
            begin
                ovf = 1;
                acc = ALL_ONES;
            end
            else
            begin
                acc = acc * b + d;
            end
            digit_seen = 1;
        endfunction

        // first character after blanks and sign
        function void first_digit(char_t c);
            if ((base == BASE_AUTO || base == BASE_HEX) && c == CH_0)
            begin
                phase = P_ZERO;
                return;
            end
            if (base == BASE_AUTO)
                base = BASE_DEC;
            phase = P_DIGITS;
            accumulate(c);
        endfunction

        // accepted input item
        function void note_char(char_t c, bit st);
            conversion_t e;
            if (st)
            begin
                acc        = '0;
                minus_seen = 0;
                digit_seen = 0;
                ovf        = 0;
                pos        = '0;
                base       = radix_reg;
                if (base != BASE_AUTO && (base < RADIX_MIN || base > RADIX_MAX))
                begin
                    e = '{value: '0, overflow: 1'b0, bad_radix: 1'b1,
                          digits_found: 1'b0, end_offset: '0};
                    expected_conversions.push_back(e);
                    phase = P_DONE;
                    return;
                end
                phase = P_SPACE;
            end
            else
            begin
                if (phase == P_IDLE || phase == P_DONE)
                    return;
                if (pos < POS_LIMIT)
                    pos = pos + 1'b1;
            end
            case (phase)
                P_SPACE:
                begin
                    if (is_blank(c))
                        return;
                    if (c == CH_MINUS)
                    begin
                        minus_seen = 1;
                        phase      = P_SIGNED;
                    end
                    else if (c == CH_PLUS)
                        phase = P_SIGNED;
                    else
                        first_digit(c);
                end
                P_SIGNED:
                    first_digit(c);
                P_ZERO:
                begin
                    if (c == CH_LX || c == CH_UX)
                    begin
                        base  = BASE_HEX;
                        phase = P_DIGITS;
                    end
                    else
                    begin
                        if (base == BASE_AUTO)
                            base = BASE_OCT;
                        acc        = '0;
                        digit_seen = 1;
                        phase      = P_DIGITS;
                        accumulate(c);
                    end
                end
                P_DIGITS:
                    accumulate(c);
                default:
                    ;
            endcase
        endfunction

        task report(string msg);
            $display("ERROR at %0t: %s", $time, msg);
            errors++;
        endtask

        // accepted result item against the oldest pending conversion
        task check_conversion(conversion_t got);
            conversion_t want;
            if (expected_conversions.size() == 0)
            begin
                report($sformatf("result with none pending, value %h", got.value));
                return;
            end
            want = expected_conversions.pop_front();
            if (got.value !== want.value)
                report($sformatf("value %h, expected %h", got.value, want.value));
            if (got.overflow !== want.overflow)
                report($sformatf("overflow %b, expected %b", got.overflow, want.overflow));
            if (got.bad_radix !== want.bad_radix)
                report($sformatf("bad_radix %b, expected %b", got.bad_radix, want.bad_radix));
            if (got.digits_found !== want.digits_found)
                report($sformatf("digits_found %b, expected %b",
                                 got.digits_found, want.digits_found));
            if (got.end_offset !== want.end_offset)
                report($sformatf("end_offset %0d, expected %0d",
                                 got.end_offset, want.end_offset));
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [RADIX_W-1:0]    radix;
    logic                  in_valid;
    logic                  in_ready;
    logic [CHAR_W-1:0]     char_code;
    logic                  start_of_string;
    logic                  out_valid;
    logic                  out_ready;
    logic [VALUE_W-1:0]    value;
    logic                  overflow;
    logic                  bad_radix;
    logic                  digits_found;
    logic [END_W-1:0]      end_offset;

    conversion_tracker tracker = new();
    char_t             line_buf[$];
    bit                idle_on;
    int                hold_token;
    int                items_sent;
    int                quiet_cycles;

    wide_string_to_unsigned dut (.*);

    // clock
    always #5 clk = ~clk;

    // random gap after an item, mostly short, a few long
    function automatic int idle_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // one character item, held until accepted
    task automatic send_char(char_t c, bit st);
        int gap;
        in_valid        <= 1'b1;
        char_code       <= c;
        start_of_string <= st;
        do
            @(posedge clk);
        while (!in_ready);
        tracker.note_char(c, st);
        items_sent++;
        gap = idle_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // the buffered string, first character opens the conversion
    task automatic send_line();
        for (int i = 0; i < line_buf.size(); i++)
            send_char(line_buf[i], i == 0);
    endtask

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(char_t'(s[i]));
    endfunction

    task automatic send_text(string s, char_t tail);
        line_buf.delete();
        put_text(s);
        line_buf.push_back(tail);
        send_line();
    endtask

    // stop sending, let every pending conversion come out, then let the pipe settle
    task automatic pause_until_done();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(negedge clk);
        @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_radix(logic [RADIX_W-1:0] r);
        cfg_valid <= 1'b1;
        radix     <= r;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        tracker.radix_reg = r;
    endtask

    function automatic char_t digit_char(int d);
        if (d < 10)
            return char_t'(CH_0 + d);
        return char_t'(($urandom_range(0, 1) ? CH_LA : CH_UA) + d - 10);
    endfunction

    function automatic logic [RADIX_W-1:0] pick_radix();
        int r;
        r = $urandom_range(0, 19);
        case (r)
            0, 1, 2, 3: return BASE_AUTO;
            4, 5:       return BASE_DEC;
            6, 7:       return BASE_HEX;
            8:          return RADIX_MIN;
            9:          return RADIX_MAX;
            10:         return BASE_OCT;
            11:         return RADIX_W'(1);
            12:         return RADIX_W'($urandom_range(37, 63));
            13:         return '1;
            default:    return RADIX_W'($urandom_range(2, 36));
        endcase
    endfunction

    // well-formed number with random blanks, sign, prefix, digits and terminator
    function automatic void build_number(logic [RADIX_W-1:0] rad);
        int b;
        int n;
        int r;
        bit nonzero_lead;
        line_buf.delete();
        nonzero_lead = 0;
        if ($urandom_range(0, 9) >= 6)
        begin
            repeat ($urandom_range(1, 3))
            begin
                r = $urandom_range(8, 13);
                line_buf.push_back(r == 8 ? CH_SPACE : char_t'(r));
            end
        end
        r = $urandom_range(0, 99);
        if (r >= 85)
            line_buf.push_back(CH_PLUS);
        else if (r >= 70)
            line_buf.push_back(CH_MINUS);
        if (rad == BASE_AUTO)
        begin
            r = $urandom_range(0, 2);
            if (r == 0)
            begin
                line_buf.push_back(CH_0);
                line_buf.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
                b = 16;
            end
            else if (r == 1)
            begin
                line_buf.push_back(CH_0);
                b = 8;
            end
            else
            begin
                b = 10;
                nonzero_lead = 1;
            end
        end
        else if (rad == BASE_HEX)
        begin
            if ($urandom_range(0, 1))
            begin
                line_buf.push_back(CH_0);
                line_buf.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
            end
            b = 16;
        end
        else if (rad < RADIX_MIN || rad > RADIX_MAX)
            b = 10;
        else
            b = rad;
        // digit count: mostly short, some long enough to overflow, a few none
        r = $urandom_range(0, 99);
        if (r < 80)
            n = $urandom_range(1, 8);
        else if (r < 94)
            n = $urandom_range(b <= 4 ? 40 : 14, 70);
        else
            n = 0;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < 2)
                line_buf.push_back(digit_char($urandom_range(0, 35)));
            else if (i == 0 && nonzero_lead)
                line_buf.push_back(digit_char($urandom_range(1, 9)));
            else
                line_buf.push_back(digit_char($urandom_range(0, b - 1)));
        end
        // terminator
        case ($urandom_range(0, 6))
            0: line_buf.push_back(CH_NUL);
            1: line_buf.push_back(CH_SPACE);
            2: line_buf.push_back(CH_DOT);
            3: line_buf.push_back(b < 36 ? digit_char($urandom_range(b, 35)) : CH_LZ + 1);
            4: line_buf.push_back(char_t'($urandom_range(128, CODE_MAX)));
            5: line_buf.push_back(CH_MINUS);
            default: line_buf.push_back(char_t'($urandom_range(0, CODE_MAX)));
        endcase
        // trailing characters after the end are dropped by the block
        if ($urandom_range(0, 4) == 0)
        begin
            repeat ($urandom_range(1, 3))
                line_buf.push_back(char_t'($urandom_range(0, CODE_MAX)));
        end
    endfunction

    // result side: check accepted items, random stalls, one long hold-off on request
    initial
    begin : receiver
        int          stall_left;
        int          hold_seen;
        conversion_t got;
        stall_left = 0;
        hold_seen  = 0;
        out_ready  = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                got.value        = value;
                got.overflow     = overflow;
                got.bad_radix    = bad_radix;
                got.digits_found = digits_found;
                got.end_offset   = end_offset;
                tracker.check_conversion(got);
            end
            if (hold_token != hold_seen)
            begin
                hold_seen  = hold_token;
                stall_left = HOLD_CYCLES;
            end
            else if (stall_left == 0 && idle_on && $urandom_range(0, 99) < 30)
            begin
                if ($urandom_range(0, 9) == 0)
                    stall_left = $urandom_range(15, 60);
                else
                    stall_left = $urandom_range(1, 3);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // stimulus
    initial
    begin : stimulus
        int random_start;
        int n_lines;
        int r;
        rst_n           = 1'b0;
        cfg_valid       = 1'b0;
        radix           = '0;
        in_valid        = 1'b0;
        char_code       = '0;
        start_of_string = 1'b0;
        idle_on         = 1;
        hold_token      = 0;
        items_sent      = 0;
        quiet_cycles    = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset radix is decimal: sign, blanks, full range, overflow, no digits
        send_text(" \t-123", CH_NUL);
        send_text("+18446744073709551615", CH_NUL);
        send_text("18446744073709551616", CH_DOT);
        send_text("-0", CH_TOP);
        line_buf.delete();
        line_buf.push_back(char_t'(8));
        put_text("7");
        send_line();
        line_buf.delete();
        line_buf.push_back(char_t'(11));
        line_buf.push_back(char_t'(12));
        line_buf.push_back(char_t'(13));
        line_buf.push_back(char_t'(10));
        line_buf.push_back(char_t'(14));
        send_line();
        send_text("-", CH_NUL);
        // characters after the end without a start are ignored
        send_char(CH_0 + 1, 1'b0);
        send_char(CH_TOP, 1'b0);
        // restart drops the open conversion
        send_char(CH_0 + 1, 1'b1);
        send_char(CH_0 + 2, 1'b0);
        send_text("34", CH_SPACE);
        pause_until_done();

        // automatic base: hex prefix, prefix without hex digit, octal, decimal
        write_radix(BASE_AUTO);
        send_text("0x1F", CH_NUL);
        send_text("0Xg", CH_NUL);
        send_text("017", CH_SPACE);
        send_text("09", CH_NUL);
        send_text("5z", CH_NUL);
        pause_until_done();

        write_radix(BASE_HEX);
        send_text("0xff", CH_NUL);
        send_text("FfFfFfFfFfFfFfFf0", CH_NUL);
        pause_until_done();

        write_radix(RADIX_MAX);
        send_text("-Zz", CH_NUL);
        pause_until_done();

        write_radix(RADIX_MIN);
        send_text("1012", CH_NUL);
        pause_until_done();

        // invalid radix gives an error on the start character
        write_radix(RADIX_W'(1));
        send_text("5", CH_NUL);
        pause_until_done();
        write_radix('1);
        send_text("5", CH_NUL);
        pause_until_done();

        // long run of leading zeros pushes the end offset far past the digit count
        write_radix(BASE_DEC);
        idle_on = 0;
        line_buf.delete();
        repeat (200) line_buf.push_back(CH_0);
        put_text("9");
        line_buf.push_back(CH_NUL);
        send_line();
        pause_until_done();

        // receiver holds off while short numbers keep coming, so the input backs up
        hold_token++;
        repeat (30)
        begin
            line_buf.delete();
            line_buf.push_back(digit_char($urandom_range(0, 9)));
            line_buf.push_back(CH_NUL);
            send_line();
        end
        pause_until_done();

        // random phases, each with its own radix and idling choice
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            write_radix(pick_radix());
            idle_on = ($urandom_range(0, 4) != 0);
            n_lines = $urandom_range(4, 16);
            repeat (n_lines)
            begin
                r = $urandom_range(0, 99);
                if (r < 85)
                begin
                    build_number(tracker.radix_reg);
                    send_line();
                end
                else if (r < 90)
                begin
                    repeat ($urandom_range(1, 4))
                        send_char(char_t'($urandom_range(0, CODE_MAX)), 1'b0);
                end
                else if (r < 95)
                begin
                    build_number(tracker.radix_reg);
                    void'(line_buf.pop_back());
                    send_line();
                end
                else
                begin
                    line_buf.delete();
                    repeat ($urandom_range(1, 6))
                        line_buf.push_back(char_t'($urandom_range(0, CODE_MAX)));
                    send_line();
                end
            end
            pause_until_done();
        end

        if (tracker.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
